>>> rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Types and constants shared by the symbol interning table modules.
// ----------------------------------------------------------------------------
package sit_pkg;

    // Result status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Prefix characters
    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] symbol_index;
        logic       is_keyword;
        logic       no_eval;
        logic       is_variadic;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic take_char;  // store the accepted character
        logic start;      // reset the scan pointer
        logic scan;       // issue one read and compare one entry
        logic latch;      // hold the search outcome
        logic finish;     // post the result, append, clear the name
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;       // search outcome known this cycle
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

>>> rtl/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sit_ctrl.sv
// ----------------------------------------------------------------------------
// sit_ctrl
// Sequencer: collects characters, runs the table scan, posts the result.
// ----------------------------------------------------------------------------
module sit_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_ready,
    input  sit_pkg::t_sts i_sts,
    output sit_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_SEARCH  = 2'd1;
    localparam logic [1:0] S_RESULT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_COLLECT: begin
                o_ready         = 1'b1;
                o_cmd.take_char = i_valid;
                if (i_valid && i_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_sts.done) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RESULT;
                end
            end
            S_RESULT: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/sit_dp.sv
// ----------------------------------------------------------------------------
// sit_dp
// Datapath: name buffer, name table memory, scan pointer, result register.
// ----------------------------------------------------------------------------
module sit_dp #(
    parameter int TABLE_ENTRIES = 256,
    parameter int NAME_CHARS    = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sit_pkg::t_in  i_data,
    input  sit_pkg::t_cmd i_cmd,
    output sit_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_ready,
    output sit_pkg::t_out o_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = $clog2(NAME_CHARS + 1);
    localparam int NW = NAME_CHARS * 8;
    localparam int EW = LW + NW;

    logic [NW-1:0]   r_name;
    logic [LW-1:0]   r_len;
    logic [IW:0]     r_used;
    logic [IW:0]     r_rd_idx;
    logic            r_pend;
    logic [IW-1:0]   r_pend_idx;
    logic            r_found;
    logic [IW-1:0]   r_res_idx;
    logic            r_out_vld;
    sit_pkg::t_out   r_out;

    logic [EW-1:0]   w_rdata;
    logic            w_re;
    logic            w_we;
    logic            w_empty;
    logic            w_hit;
    logic            w_full;
    logic [NW+15:0]  w_pad;
    logic [7:0]      w_b0, w_b1, w_b2, w_b3, w_b4;
    logic            w_pre0, w_pre1;
    logic            w_var;
    sit_pkg::t_out   w_res;

    sit_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_used[IW-1:0]),
        .i_wdata ({r_len, r_name}),
        .i_re    (w_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // Entry 0 is the empty name and is never stored; it is matched by length.
    assign w_empty = (r_len == '0);
    assign w_hit   = r_pend && (w_rdata == {r_len, r_name});
    assign w_full  = (r_used >= (IW+1)'(TABLE_ENTRIES));
    assign w_re    = i_cmd.scan && (r_rd_idx < r_used);
    assign w_we    = i_cmd.finish && !r_found && !w_full;

    assign o_sts.done     = w_empty || w_hit || (r_rd_idx >= r_used);
    assign o_sts.out_free = !r_out_vld || i_ready;

    // Prefix flags; positions past the name read as zero
    assign w_pad  = {16'h0000, r_name};
    assign w_b0   = w_pad[7:0];
    assign w_b1   = w_pad[15:8];
    assign w_b2   = w_pad[23:16];
    assign w_b3   = w_pad[31:24];
    assign w_b4   = w_pad[39:32];
    assign w_pre0 = (w_b0 == sit_pkg::CH_AT) || (w_b0 == sit_pkg::CH_AMP);
    assign w_pre1 = (w_b1 == sit_pkg::CH_AT) || (w_b1 == sit_pkg::CH_AMP);

    always_comb begin
        if (!w_pre0) begin
            w_var = (w_b0 == sit_pkg::CH_DOT) && (w_b1 == sit_pkg::CH_DOT)
                 && (w_b2 == sit_pkg::CH_DOT);
        end else if (!w_pre1) begin
            w_var = (w_b1 == sit_pkg::CH_DOT) && (w_b2 == sit_pkg::CH_DOT)
                 && (w_b3 == sit_pkg::CH_DOT);
        end else begin
            w_var = (w_b2 == sit_pkg::CH_DOT) && (w_b3 == sit_pkg::CH_DOT)
                 && (w_b4 == sit_pkg::CH_DOT);
        end
    end

    always_comb begin
        w_res.is_keyword  = (w_b0 == sit_pkg::CH_COLON);
        w_res.no_eval     = (w_b0 == sit_pkg::CH_AT)
                         || ((w_b0 == sit_pkg::CH_AMP) && (w_b1 == sit_pkg::CH_AT));
        w_res.is_variadic = w_var;
        if (r_found) begin
            w_res.status       = sit_pkg::ST_FOUND;
            w_res.symbol_index = 8'(r_res_idx);
        end else if (w_full) begin
            w_res = '0;
            w_res.status = sit_pkg::ST_OVERFLOW;
        end else begin
            w_res.status       = sit_pkg::ST_INSERTED;
            w_res.symbol_index = 8'(r_used[IW-1:0]);
        end
    end

    // Name buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name <= '0;
            r_len  <= '0;
        end else if (i_cmd.finish) begin
            r_name <= '0;
            r_len  <= '0;
        end else if (i_cmd.take_char && (i_data.char_code != sit_pkg::CH_NONE)
                     && (r_len < LW'(NAME_CHARS))) begin
            for (int k = 0; k < NAME_CHARS; k++) begin
                if (r_len == LW'(k)) begin
                    r_name[k*8 +: 8] <= i_data.char_code;
                end
            end
            r_len <= r_len + 1'b1;
        end
    end

    // Scan pointer and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= (IW+1)'(1);
            r_rd_idx <= (IW+1)'(1);
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_rd_idx <= (IW+1)'(1);
                r_pend   <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= w_re;
                if (w_re) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (i_cmd.latch) begin
                r_found <= w_empty || w_hit;
            end
            if (w_we) begin
                r_used <= r_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_pend_idx <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.latch) begin
            r_res_idx <= w_empty ? '0 : r_pend_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

>>> rtl/symbol_interning_table.sv
// ----------------------------------------------------------------------------
// symbol_interning_table
// Interns symbol names streamed one character per item and returns the
// table index with prefix flags.
// ----------------------------------------------------------------------------
//  channel | signals                      | moves
//  --------+------------------------------+-------------------------------
//  input   | i_valid / o_ready / i_data   | one name character per item
//  output  | o_valid / i_ready / o_data   | one lookup result per name
//
// A non-last character item is stored in the name buffer. A last item scans
// the table memory one entry per cycle over its single read port, then posts
// the result. Synchronous active-low reset leaves entry 0 (the empty name)
// as the only entry; no clearing pass. Characters are taken while a result
// waits in the output register; a new result stalls only until that
// register frees.
// ----------------------------------------------------------------------------
module symbol_interning_table #(
    parameter int TABLE_ENTRIES = 256,
    parameter int NAME_CHARS    = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sit_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sit_pkg::t_out o_data
);

    sit_pkg::t_cmd w_cmd;
    sit_pkg::t_sts w_sts;

    sit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_data.last_char),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sit_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_CHARS    (NAME_CHARS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

>>> rtl/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks on the symbol interning table, bound to the top level.
// ----------------------------------------------------------------------------
module sit_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input sit_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input sit_pkg::t_out o_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == sit_pkg::ST_FOUND)
                 || (o_data.status == sit_pkg::ST_INSERTED)
                 || (o_data.status == sit_pkg::ST_OVERFLOW))
        else $error("bad status code");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == sit_pkg::ST_OVERFLOW) |->
            (o_data.symbol_index == 8'd0) && !o_data.is_keyword
            && !o_data.no_eval && !o_data.is_variadic)
        else $error("overflow result carries data");

    // first character cannot be both ':' and a prefix
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.is_keyword && o_data.no_eval))
        else $error("keyword and no-eval both set");

endmodule

bind symbol_interning_table sit_checker u_sit_checker (.*);

>>> test/tb_symbol_interning_table.sv
// ----------------------------------------------------------------------------
// tb_symbol_interning_table
// Streams symbol names into the interning table one character item at a time.
// Results are checked against a local model of the table. The stimulus starts
// with a few prefix and empty-name cases. Random names follow, with repeats,
// zero characters and names past the length limit. The table is then filled
// to overflow, and a short random tail runs against the full table.
// ----------------------------------------------------------------------------
module tb_symbol_interning_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 256;
    localparam int NAME_CHARS    = 31;
    localparam int MAX_WORD      = 40;
    localparam int BANK_SIZE     = 1024;
    localparam int RANDOM_ITEMS  = 220;
    localparam int HOLD_AT       = 15;
    localparam int HOLD_LEN      = 400;
    localparam int CALM_LO       = 60;
    localparam int CALM_HI       = 110;
    localparam int FEED_CALM_LO  = 300;
    localparam int FEED_CALM_HI  = 450;
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 32;
    localparam int STALL_LIMIT   = 5000;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    sit_pkg::t_in  in_data   = '0;
    logic          in_ready;
    logic          out_valid;
    logic          out_ready = 1'b0;
    sit_pkg::t_out out_data;

    symbol_interning_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NAME_CHARS   (NAME_CHARS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(in_ready),
        .i_data (in_data),
        .o_valid(out_valid),
        .i_ready(out_ready),
        .o_data (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model of the table
    logic [7:0] held [NAME_CHARS];
    int         held_len = 0;
    logic [7:0] tbl_chars [TABLE_ENTRIES][NAME_CHARS];
    int         tbl_len [TABLE_ENTRIES];
    int         tbl_used = 1;

    sit_pkg::t_out expected_results [$];
    sit_pkg::t_in  char_items [$];

    // Names sent so far, kept for repeats
    logic [7:0] word_bank [BANK_SIZE][MAX_WORD];
    int         word_len [BANK_SIZE];
    int         bank_count = 0;

    int items_queued = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int errors       = 0;
    int hold_left    = 0;
    bit held_off     = 1'b0;
    int idle_cycles  = 0;

    function automatic logic [7:0] held_char(int pos);
        return (pos < held_len) ? held[pos] : sit_pkg::CH_NONE;
    endfunction

    function automatic bit is_prefix(logic [7:0] c);
        return c == sit_pkg::CH_AT || c == sit_pkg::CH_AMP;
    endfunction

    function automatic bit entry_equals_held(int e);
        if (tbl_len[e] != held_len) return 1'b0;
        for (int i = 0; i < held_len; i++)
            if (tbl_chars[e][i] != held[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic intern_char(sit_pkg::t_in it);
        sit_pkg::t_out res;
        int   hit;
        int   p;
        if (it.char_code != sit_pkg::CH_NONE && held_len < NAME_CHARS) begin
            held[held_len] = it.char_code;
            held_len++;
        end
        if (it.last_char) begin
            hit = -1;
            for (int e = 0; e < tbl_used && hit < 0; e++)
                if (entry_equals_held(e)) hit = e;
            res = '0;
            if (hit >= 0) begin
                res.status       = sit_pkg::ST_FOUND;
                res.symbol_index = 8'(hit);
            end else if (tbl_used >= TABLE_ENTRIES) begin
                res.status = sit_pkg::ST_OVERFLOW;
            end else begin
                res.status       = sit_pkg::ST_INSERTED;
                res.symbol_index = 8'(tbl_used);
                for (int i = 0; i < NAME_CHARS; i++) tbl_chars[tbl_used][i] = held_char(i);
                tbl_len[tbl_used] = held_len;
                tbl_used++;
            end
            if (res.status != sit_pkg::ST_OVERFLOW) begin
                // skip up to two at/ampersand prefixes before the dots
                p = 0;
                if (is_prefix(held_char(p))) p++;
                if (is_prefix(held_char(p))) p++;
                res.is_variadic = held_char(p) == sit_pkg::CH_DOT &&
                                  held_char(p + 1) == sit_pkg::CH_DOT &&
                                  held_char(p + 2) == sit_pkg::CH_DOT;
                res.is_keyword  = held_char(0) == sit_pkg::CH_COLON;
                res.no_eval     = held_char(0) == sit_pkg::CH_AT ||
                                  (held_char(0) == sit_pkg::CH_AMP &&
                                   held_char(1) == sit_pkg::CH_AT);
            end
            expected_results.push_back(res);
            held_len = 0;
            for (int i = 0; i < NAME_CHARS; i++) held[i] = sit_pkg::CH_NONE;
        end
    endtask

    task automatic check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Driver: offer queued items, model each one as it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                intern_char(in_data);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (char_items.size() > 0 &&
                    ((items_taken >= FEED_CALM_LO && items_taken < FEED_CALM_HI) ||
                     $urandom_range(0, 99) >= 33)) begin
                    in_data  <= char_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, stall the output at random and once for long
    always @(posedge clk) begin
        sit_pkg::t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %p", $time, out_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("symbol_index", want.symbol_index, out_data.symbol_index);
                    check_field("is_keyword", want.is_keyword, out_data.is_keyword);
                    check_field("no_eval", want.no_eval, out_data.no_eval);
                    check_field("is_variadic", want.is_variadic, out_data.is_variadic);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!held_off && results_seen == HOLD_AT) begin
                // hold off so the block backs up and stalls its input
                held_off  = 1'b1;
                hold_left = HOLD_LEN;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                             $urandom_range(0, 99) >= 33;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_symbol_interning_table failed");
            $finish;
        end
    end

    task automatic push_char(logic [7:0] c, logic last);
        char_items.push_back(sit_pkg::t_in'{char_code: c, last_char: last});
        items_queued++;
    endtask

    function automatic logic [7:0] pick_char(int style);
        case (style)
            0: return 8'($urandom_range(1, 255));
            1: return 8'h61 + 8'($urandom_range(0, 2));
            default: begin
                case ($urandom_range(0, 4))
                    0: return sit_pkg::CH_AT;
                    1: return sit_pkg::CH_AMP;
                    2: return sit_pkg::CH_DOT;
                    3: return sit_pkg::CH_COLON;
                    default: return 8'h78;
                endcase
            end
        endcase
    endfunction

    task automatic claim_slot(output int idx);
        if (bank_count < BANK_SIZE) begin
            idx = bank_count;
            bank_count++;
        end else begin
            idx = $urandom_range(0, BANK_SIZE - 1);
        end
    endtask

    task automatic make_word(int n, int style, output int idx);
        claim_slot(idx);
        for (int i = 0; i < n; i++) word_bank[idx][i] = pick_char(style);
        word_len[idx] = n;
    endtask

    // Queue one name; noisy adds zero items, vary_tail changes dropped characters
    task automatic queue_word(int idx, bit noisy, bit vary_tail);
        int         n;
        bit         zero_end;
        logic [7:0] c;
        n        = word_len[idx];
        zero_end = (n == 0) || (noisy && $urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) push_char(sit_pkg::CH_NONE, 1'b0);
            c = (vary_tail && i >= NAME_CHARS) ? 8'($urandom_range(1, 255)) : word_bank[idx][i];
            push_char(c, !zero_end && i == n - 1);
        end
        if (zero_end) push_char(sit_pkg::CH_NONE, 1'b1);
    endtask

    task automatic add_word(string s);
        int idx;
        claim_slot(idx);
        for (int i = 0; i < s.len(); i++) word_bank[idx][i] = s[i];
        word_len[idx] = s.len();
        queue_word(idx, 1'b0, 1'b0);
    endtask

    task automatic wait_drained();
        while (char_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        int idx;
        int n;
        int roll;
        int random_goal;

        tbl_len[0] = 0;
        for (int i = 0; i < NAME_CHARS; i++) held[i] = sit_pkg::CH_NONE;

        add_word("");
        add_word(":");
        add_word("@...");
        add_word("&@x");
        add_word("&&...");
        add_word("..");
        add_word(":");
        push_char(8'hFF, 1'b0);
        push_char(8'h01, 1'b1);
        // zero items inside and at the end of a name
        push_char(8'h61, 1'b0);
        push_char(sit_pkg::CH_NONE, 1'b0);
        push_char(8'h62, 1'b0);
        push_char(sit_pkg::CH_NONE, 1'b1);
        add_word("ab");

        random_goal = items_queued + RANDOM_ITEMS;
        while (items_queued < random_goal) begin
            if (bank_count > 0 && $urandom_range(0, 99) < 35) begin
                idx = $urandom_range(0, bank_count - 1);
                queue_word(idx, 1'b1, word_len[idx] > NAME_CHARS);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) n = $urandom_range(0, 3);
                else if (roll < 90) n = $urandom_range(4, 12);
                else n = $urandom_range(NAME_CHARS - 1, MAX_WORD);
                make_word(n, $urandom_range(0, 2), idx);
                queue_word(idx, 1'b1, 1'b0);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        // every one-character name: with the empty name these fill the table
        for (int c = 1; c < 256; c++) push_char(8'(c), 1'b1);
        wait_drained();

        // full table: known names still hit, new ones overflow
        add_word("");
        repeat (30) begin
            if ($urandom_range(0, 1) == 0) begin
                idx = $urandom_range(0, bank_count - 1);
                queue_word(idx, 1'b1, word_len[idx] > NAME_CHARS);
            end else begin
                make_word($urandom_range(1, 6), $urandom_range(0, 2), idx);
                queue_word(idx, 1'b1, 1'b0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0) begin
            $display("%0t missing results: expected %0d actual 0", $time,
                     expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb_symbol_interning_table passed");
        end else begin
            $display("tb_symbol_interning_table failed");
        end
        $finish;
    end

endmodule
